// ===== sv/apg_pkg.sv =====
package apg_pkg;

  localparam int CordicIters = 24;
  localparam int OffW = 42;
  localparam int AccW = 44;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VEC_A,
    ST_RADIUS,
    ST_VEC_B,
    ST_SPAN,
    ST_DIV,
    ST_ROT,
    ST_MUL,
    ST_OUT
  } apg_state_t;

  typedef struct packed {
    logic load;
    logic vec_a_init;
    logic vec_b_init;
    logic cordic_step;
    logic radius_calc;
    logic span_calc;
    logic div_init;
    logic div_step;
    logic rot_init;
    logic mul_calc;
    logic out_load;
    logic point_adv;
  } apg_cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic div_done;
    logic last_done;
  } apg_status_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'd536870912;
        5'd1: r = 32'd316933406;
        5'd2: r = 32'd167458907;
        5'd3: r = 32'd85004756;
        5'd4: r = 32'd42667331;
        5'd5: r = 32'd21354465;
        5'd6: r = 32'd10679838;
        5'd7: r = 32'd5340245;
        5'd8: r = 32'd2670163;
        5'd9: r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        5'd20: r = 32'd652;
        5'd21: r = 32'd326;
        5'd22: r = 32'd163;
        5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== sv/apg_control.sv =====
module apg_control
  import apg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  apg_status_t status,
  output apg_cmd_t    cmd
);

  apg_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_VEC_A;
      ST_VEC_A: if (status.cordic_done) state_next = ST_RADIUS;
      ST_RADIUS: state_next = ST_VEC_B;
      ST_VEC_B: if (status.cordic_done) state_next = ST_SPAN;
      ST_SPAN: state_next = ST_ROT;
      ST_ROT: if (status.cordic_done) state_next = ST_MUL;
      ST_MUL: state_next = ST_OUT;
      ST_OUT: begin
        if (!out_stall) begin
          state_next = status.last_done ? ST_IDLE : ST_DIV;
        end
      end
      ST_DIV: if (status.div_done) state_next = ST_ROT;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        cmd.vec_a_init = in_valid;
      end
      ST_VEC_A: cmd.cordic_step = 1'b1;
      ST_RADIUS: begin
        cmd.radius_calc = 1'b1;
        cmd.vec_b_init = 1'b1;
      end
      ST_VEC_B: cmd.cordic_step = 1'b1;
      ST_SPAN: begin
        cmd.span_calc = 1'b1;
        cmd.rot_init = 1'b1;
      end
      ST_ROT: cmd.cordic_step = 1'b1;
      ST_MUL: cmd.mul_calc = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall && !status.last_done) begin
          cmd.point_adv = 1'b1;
          cmd.div_init = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.rot_init = status.div_done;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== sv/apg_datapath.sv =====
module apg_datapath
  import apg_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  apg_cmd_t           cmd,
  output apg_status_t        status,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic signed [31:0] height_z,
  input  logic [6:0]         point_count,
  input  logic               counter_clockwise,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic               last_point
);

  localparam int CntW = $clog2(MAX_POINTS + 1);
  localparam int NumW = CntW + 32;

  logic signed [31:0] cx, cy, hz;
  logic signed [OffW-1:0] bxo, byo;
  logic [CntW-1:0] n, idx;
  logic rev;
  logic signed [AccW-1:0] x, y;
  logic signed [33:0] z;
  logic [4:0] it;
  logic rot_mode, flip;
  logic [31:0] pa, span;
  logic zero_b;
  logic [32:0] radius;
  logic [NumW-1:0] rem;
  logic [31:0] quo;
  logic [5:0] dcnt;
  logic signed [65:0] prod_x, prod_y;

  logic [6:0] pc_sat;
  logic [CntW-1:0] n_in;
  logic signed [OffW-1:0] axi, ayi, bxi, byi;
  logic signed [AccW-1:0] xs, ys;
  logic signed [33:0] at;
  logic [31:0] ang;

  always_comb begin
    pc_sat = (point_count < 7'd2) ? 7'd2 : point_count;
    if ({{(32-7){1'b0}}, pc_sat} > 32'(MAX_POINTS)) begin
      n_in = CntW'(MAX_POINTS);
    end else begin
      n_in = CntW'(pc_sat);
    end
    axi = OffW'(34'(start_x) - 34'(center_x)) <<< 8;
    ayi = OffW'(34'(start_y) - 34'(center_y)) <<< 8;
    bxi = OffW'(34'(end_x) - 34'(center_x)) <<< 8;
    byi = OffW'(34'(end_y) - 34'(center_y)) <<< 8;
    xs = x >>> it;
    ys = y >>> it;
    at = $signed({2'b00, atan_entry(it)});
    ang = pa + quo;
  end

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] c,
                                                 input logic signed [65:0] p);
    logic signed [65:0] s;
    begin
      s = (p + 66'sd536870912) >>> 30;
      s = s + 66'(c);
      if (s > 66'sd2147483647) return 32'h7fffffff;
      if (s < -66'sd2147483648) return 32'h80000000;
      return s[31:0];
    end
  endfunction

  function automatic logic [CntW-1:0] k_next_val();
    logic [CntW-1:0] i1;
    begin
      i1 = idx + CntW'(1);
      return rev ? (n - CntW'(1) - i1) : i1;
    end
  endfunction

  function automatic logic [31:0] span_calc_now();
    logic signed [31:0] d;
    begin
      d = $signed(z[31:0] - pa);
      if (zero_b) return 32'd0;
      return d[31] ? 32'(-33'(d)) : 32'(d);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx <= center_x;
      cy <= center_y;
      hz <= height_z;
      bxo <= bxi;
      byo <= byi;
      n <= n_in;
      rev <= counter_clockwise;
      idx <= '0;
      quo <= '0;
    end
    if (cmd.vec_a_init || cmd.vec_b_init) begin
      logic signed [OffW-1:0] vx, vy;
      vx = cmd.vec_a_init ? axi : bxo;
      vy = cmd.vec_a_init ? ayi : byo;
      rot_mode <= 1'b0;
      it <= '0;
      if (vx < 0) begin
        x <= -AccW'(vx);
        y <= -AccW'(vy);
        z <= 34'sh080000000;
      end else begin
        x <= AccW'(vx);
        y <= AccW'(vy);
        z <= '0;
      end
      if (cmd.vec_b_init) zero_b <= (bxo == 0) && (byo == 0);
    end
    if (cmd.rot_init) begin
      logic [31:0] a;
      a = cmd.span_calc ? pa : ang;
      if (cmd.span_calc && rev) a = pa + span_calc_now();
      rot_mode <= 1'b1;
      it <= '0;
      x <= AccW'(652032874);
      y <= '0;
      if ($signed(a) > 32'sh40000000 || $signed(a) < -32'sh40000000) begin
        z <= 34'($signed(a - 32'h80000000));
        flip <= 1'b1;
      end else begin
        z <= 34'($signed(a));
        flip <= 1'b0;
      end
    end
    if (cmd.cordic_step) begin
      it <= it + 5'd1;
      if (rot_mode ? (z >= 0) : (y > 0)) begin
        x <= rot_mode ? x - ys : x + ys;
        y <= rot_mode ? y + xs : y - xs;
        z <= rot_mode ? z - at : z + at;
      end else begin
        x <= rot_mode ? x + ys : x - ys;
        y <= rot_mode ? y - xs : y + xs;
        z <= rot_mode ? z + at : z - at;
      end
    end
    if (cmd.radius_calc) begin
      logic [63:0] hi, lo;
      pa <= z[31:0];
      hi = 64'(x[AccW-1:21]) * 64'd2608131496;
      lo = (64'(x[20:0]) * 64'd2608131496) >> 21;
      radius <= 33'((hi + lo + 64'd262144) >> 19);
    end
    if (cmd.span_calc) begin
      span <= span_calc_now();
    end
    if (cmd.div_init) begin
      idx <= idx + CntW'(1);
      rem <= NumW'(k_next_val()) * NumW'(span);
      quo <= '0;
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      logic [NumW:0] trial;
      trial = {rem, 1'b0} - ({1'b0, NumW'(n - CntW'(1))} << 32);
      dcnt <= dcnt + 6'd1;
      if (!trial[NumW]) begin
        rem <= trial[NumW-1:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[NumW-2:0], 1'b0};
        quo <= {quo[30:0], 1'b0};
      end
    end
    if (cmd.mul_calc) begin
      logic signed [31:0] c, s;
      c = flip ? 32'(-x) : 32'(x);
      s = flip ? 32'(-y) : 32'(y);
      prod_x <= $signed({1'b0, radius}) * 66'(c);
      prod_y <= $signed({1'b0, radius}) * 66'(s);
    end
    if (cmd.out_load || cmd.mul_calc) begin
      point_z <= hz;
    end
  end

  assign point_x = sat_add(cx, prod_x);
  assign point_y = sat_add(cy, prod_y);
  assign last_point = (idx == n - CntW'(1));

  assign status.cordic_done = (it == 5'(CordicIters - 1)) && cmd.cordic_step;
  assign status.div_done = (dcnt == 6'd32);
  assign status.last_done = last_point;

  logic unused;
  assign unused = ^{rst, cmd.point_adv, rem[NumW-1]};

endmodule

// ===== sv/arc_point_generator_unit.sv =====
// Arc point generator.
// The input channel takes one arc request per word: center, start point,
// end point, z, point count and winding flag. The output channel returns
// one word per arc point, with last_point set on the final point.
// Setup runs two 24-step CORDIC vectoring passes (start and end phase),
// the radius product and the span. The first point then takes a
// 24-step CORDIC rotation and a multiply before it is offered. Each
// further point takes a restoring division for its angle offset, the
// rotation and the multiply after the previous point is taken. The serial
// divider and the shared CORDIC unit set the rate.
// One request is worked on at a time; in_stall stays high until its last
// point has been taken.
// A point waits in the output register while out_stall is high, and the
// block makes no progress until it is taken.
// Synchronous reset returns the controller to idle; any arc in flight is
// dropped.
module arc_point_generator_unit
  import apg_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic signed [31:0] height_z,
  input  logic [6:0]         point_count,
  input  logic               counter_clockwise,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic               last_point
);

  apg_cmd_t cmd;
  apg_status_t status;

  apg_control u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
  );

  apg_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .center_x(center_x), .center_y(center_y), .start_x(start_x),
    .start_y(start_y), .end_x(end_x), .end_y(end_y), .height_z(height_z),
    .point_count(point_count), .counter_clockwise(counter_clockwise),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .last_point(last_point)
  );

endmodule
